[hdl/ecfsr_pkg.sv]
`timescale 1ns / 1ps

package ecfsr_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CPU_MAX    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GPU_MAX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_ADDR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GPU_ADDR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT = 3'd4;

    localparam logic [15:0] RST_CPU_MAX    = 16'd7055;
    localparam logic [15:0] RST_GPU_MAX    = 16'd7400;
    localparam logic [7:0]  RST_CPU_ADDR   = 8'h64;
    localparam logic [7:0]  RST_GPU_ADDR   = 8'h6C;
    localparam logic [15:0] RST_POLL_LIMIT = 16'd1000;

    // controller protocol
    localparam logic [7:0] EC_READ_CMD = 8'h80;
    localparam int         IBF_BIT     = 1;
    localparam int         OBF_BIT     = 0;
    localparam logic       PORT_DATA   = 1'b0;
    localparam logic       PORT_CMD    = 1'b1;

    localparam logic       OP_START    = 1'b0;
    localparam logic       OP_DATA     = 1'b1;

    localparam logic [1:0] ACC_READ    = 2'd0;
    localparam logic [1:0] ACC_WRITE   = 2'd1;
    localparam logic [1:0] ACC_DONE    = 2'd2;
    localparam logic [1:0] ACC_FAIL    = 2'd3;

    // percentage in tenths: (speed * 1000 + max / 2) / max
    localparam logic [9:0] PCT_SCALE = 10'd1000;
    localparam int         NUM_W     = 26;
    localparam int         DIV_CNT_W = $clog2(NUM_W + 1);

    typedef struct packed {
        logic       opcode;
        logic       fan_choice;
        logic [7:0] port_data;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  access_kind;
        logic        port_select;
        logic [7:0]  write_value;
        logic        report_fan;
        logic [15:0] fan_speed;
        logic [15:0] percent_tenths;
        logic        last_of_run;
    } out_item_t;

    typedef enum logic [2:0] {
        EMIT_POLL,
        EMIT_WR_CMD,
        EMIT_WR_ADDR,
        EMIT_RD_DATA,
        EMIT_DONE,
        EMIT_FAIL
    } emit_t;

    typedef struct packed {
        logic  start;
        logic  poll_reset;
        logic  poll_inc;
        logic  capture_high;
        logic  capture_low;
        logic  div_init;
        logic  div_step;
        logic  load_out;
        emit_t emit;
        logic  last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic opcode;
        logic ibf;
        logic obf;
        logic low_half;
        logic poll_done;
        logic div_done;
    } dp_status_t;

endpackage

[hdl/ecfsr_ctrl.sv]
`timescale 1ns / 1ps

module ecfsr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  ecfsr_pkg::dp_status_t status,
    output ecfsr_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT_CMD,
        PH_WAIT_ADDR,
        PH_WAIT_OBF,
        PH_WAIT_DATA
    } phase_t;

    typedef enum logic [2:0] {
        S_IN,
        S_OUT,
        S_OUT_PAIR,
        S_CALC,
        S_DIV
    } seq_t;

    phase_t phase_reg, phase_next;
    seq_t   seq_reg, seq_next;
    logic   do_retry;

    assign in_stall  = (seq_reg != S_IN);
    assign out_valid = (seq_reg == S_OUT) || (seq_reg == S_OUT_PAIR);

    always_comb
    begin
        cmd        = '0;
        cmd.emit   = ecfsr_pkg::EMIT_POLL;
        seq_next   = seq_reg;
        phase_next = phase_reg;
        do_retry   = 1'b0;

        case (seq_reg)
            S_IN:
            begin
                if (in_valid)
                begin
                    if (status.opcode == ecfsr_pkg::OP_START)
                    begin
                        cmd.start      = 1'b1;
                        cmd.poll_reset = 1'b1;
                        cmd.load_out   = 1'b1;
                        cmd.emit       = ecfsr_pkg::EMIT_POLL;
                        cmd.last       = 1'b1;
                        phase_next     = PH_WAIT_CMD;
                        seq_next       = S_OUT;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_IDLE:
                            begin
                            end
                            PH_WAIT_CMD:
                            begin
                                if (status.ibf)
                                    do_retry = 1'b1;
                                else
                                begin
                                    cmd.poll_reset = 1'b1;
                                    cmd.load_out   = 1'b1;
                                    cmd.emit       = ecfsr_pkg::EMIT_WR_CMD;
                                    phase_next     = PH_WAIT_ADDR;
                                    seq_next       = S_OUT_PAIR;
                                end
                            end
                            PH_WAIT_ADDR:
                            begin
                                if (status.ibf)
                                    do_retry = 1'b1;
                                else
                                begin
                                    cmd.poll_reset = 1'b1;
                                    cmd.load_out   = 1'b1;
                                    cmd.emit       = ecfsr_pkg::EMIT_WR_ADDR;
                                    phase_next     = PH_WAIT_OBF;
                                    seq_next       = S_OUT_PAIR;
                                end
                            end
                            PH_WAIT_OBF:
                            begin
                                if (!status.obf)
                                    do_retry = 1'b1;
                                else
                                begin
                                    cmd.load_out = 1'b1;
                                    cmd.emit     = ecfsr_pkg::EMIT_RD_DATA;
                                    cmd.last     = 1'b1;
                                    phase_next   = PH_WAIT_DATA;
                                    seq_next     = S_OUT;
                                end
                            end
                            PH_WAIT_DATA:
                            begin
                                if (!status.low_half)
                                begin
                                    cmd.capture_high = 1'b1;
                                    cmd.poll_reset   = 1'b1;
                                    cmd.load_out     = 1'b1;
                                    cmd.emit         = ecfsr_pkg::EMIT_POLL;
                                    cmd.last         = 1'b1;
                                    phase_next       = PH_WAIT_CMD;
                                    seq_next         = S_OUT;
                                end
                                else
                                begin
                                    cmd.capture_low = 1'b1;
                                    phase_next      = PH_IDLE;
                                    seq_next        = S_CALC;
                                end
                            end
                            default:
                                phase_next = PH_IDLE;
                        endcase
                    end
                end
            end
            S_OUT_PAIR:
            begin
                // first of two results taken, follow with a status poll
                if (!out_stall)
                begin
                    cmd.load_out = 1'b1;
                    cmd.emit     = ecfsr_pkg::EMIT_POLL;
                    cmd.last     = 1'b1;
                    seq_next     = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                    seq_next = S_IN;
            end
            S_CALC:
            begin
                cmd.div_init = 1'b1;
                seq_next     = S_DIV;
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.load_out = 1'b1;
                    cmd.emit     = ecfsr_pkg::EMIT_DONE;
                    cmd.last     = 1'b1;
                    seq_next     = S_OUT;
                end
                else
                    cmd.div_step = 1'b1;
            end
            default:
                seq_next = S_IN;
        endcase

        if (do_retry)
        begin
            cmd.load_out = 1'b1;
            cmd.last     = 1'b1;
            seq_next     = S_OUT;
            if (status.poll_done)
            begin
                cmd.emit   = ecfsr_pkg::EMIT_FAIL;
                phase_next = PH_IDLE;
            end
            else
            begin
                cmd.emit     = ecfsr_pkg::EMIT_POLL;
                cmd.poll_inc = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            seq_reg   <= S_IN;
        end
        else
        begin
            phase_reg <= phase_next;
            seq_reg   <= seq_next;
        end
    end

endmodule

[hdl/ecfsr_dp.sv]
`timescale 1ns / 1ps

module ecfsr_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [ecfsr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ecfsr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  ecfsr_pkg::in_item_t                  in_item,
    input  ecfsr_pkg::ctrl_cmd_t                 cmd,
    output ecfsr_pkg::dp_status_t                status,
    output ecfsr_pkg::out_item_t                 out_item
);

    localparam int NW = ecfsr_pkg::NUM_W;
    localparam int CW = ecfsr_pkg::DIV_CNT_W;

    logic [15:0] cpu_max_reg, gpu_max_reg, poll_limit_reg;
    logic [7:0]  cpu_addr_reg, gpu_addr_reg;

    logic        active_fan_reg, active_fan_next;
    logic        low_half_reg;
    logic [15:0] poll_count_reg;
    logic [7:0]  speed_high_reg;
    logic [15:0] speed_reg;

    logic [NW-1:0]                     num_reg;
    logic [15:0]                       rem_reg;
    logic [15:0]                       div_reg;
    logic [CW-1:0]                     cnt_reg;

    ecfsr_pkg::out_item_t out_reg, out_next;

    logic [15:0]   max_sel, max_eff, poll_lim;
    logic [7:0]    byte_addr;
    logic [NW-1:0] num_init;
    logic [16:0]   rem_shift;
    logic [15:0]   rem_diff;
    logic          q_bit;
    logic [15:0]   pct;

    always_comb
    begin
        max_sel = active_fan_reg ? gpu_max_reg : cpu_max_reg;
        if (max_sel == 16'd0)
            max_eff = active_fan_reg ? ecfsr_pkg::RST_GPU_MAX : ecfsr_pkg::RST_CPU_MAX;
        else
            max_eff = max_sel;
        poll_lim  = (poll_limit_reg == 16'd0) ? 16'd1 : poll_limit_reg;
        byte_addr = (active_fan_reg ? gpu_addr_reg : cpu_addr_reg) + {7'd0, low_half_reg};
        num_init  = NW'(speed_reg) * NW'(ecfsr_pkg::PCT_SCALE) + NW'(max_eff[15:1]);

        // one restoring step per cycle, quotient bits shift into num_reg
        rem_shift = {rem_reg, num_reg[NW-1]};
        // difference is below the divisor whenever it is used, so 16 bits hold it
        rem_diff  = rem_shift[15:0] - div_reg;
        q_bit     = (rem_shift >= {1'b0, div_reg});

        pct = (|num_reg[NW-1:16]) ? 16'hFFFF : num_reg[15:0];

        active_fan_next = cmd.start ? in_item.fan_choice : active_fan_reg;
    end

    always_comb
    begin
        status.opcode    = in_item.opcode;
        status.ibf       = in_item.port_data[ecfsr_pkg::IBF_BIT];
        status.obf       = in_item.port_data[ecfsr_pkg::OBF_BIT];
        status.low_half  = low_half_reg;
        status.poll_done = (poll_count_reg >= poll_lim);
        status.div_done  = (cnt_reg == '0);
    end

    always_comb
    begin
        out_next             = '0;
        out_next.report_fan  = active_fan_next;
        out_next.last_of_run = cmd.last;
        case (cmd.emit)
            ecfsr_pkg::EMIT_POLL:
            begin
                out_next.access_kind = ecfsr_pkg::ACC_READ;
                out_next.port_select = ecfsr_pkg::PORT_CMD;
            end
            ecfsr_pkg::EMIT_WR_CMD:
            begin
                out_next.access_kind = ecfsr_pkg::ACC_WRITE;
                out_next.port_select = ecfsr_pkg::PORT_CMD;
                out_next.write_value = ecfsr_pkg::EC_READ_CMD;
            end
            ecfsr_pkg::EMIT_WR_ADDR:
            begin
                out_next.access_kind = ecfsr_pkg::ACC_WRITE;
                out_next.port_select = ecfsr_pkg::PORT_DATA;
                out_next.write_value = byte_addr;
            end
            ecfsr_pkg::EMIT_RD_DATA:
            begin
                out_next.access_kind = ecfsr_pkg::ACC_READ;
                out_next.port_select = ecfsr_pkg::PORT_DATA;
            end
            ecfsr_pkg::EMIT_DONE:
            begin
                out_next.access_kind    = ecfsr_pkg::ACC_DONE;
                out_next.fan_speed      = speed_reg;
                out_next.percent_tenths = pct;
            end
            ecfsr_pkg::EMIT_FAIL:
                out_next.access_kind = ecfsr_pkg::ACC_FAIL;
            default:
                out_next.access_kind = ecfsr_pkg::ACC_FAIL;
        endcase
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_max_reg    <= ecfsr_pkg::RST_CPU_MAX;
            gpu_max_reg    <= ecfsr_pkg::RST_GPU_MAX;
            cpu_addr_reg   <= ecfsr_pkg::RST_CPU_ADDR;
            gpu_addr_reg   <= ecfsr_pkg::RST_GPU_ADDR;
            poll_limit_reg <= ecfsr_pkg::RST_POLL_LIMIT;
            active_fan_reg <= 1'b0;
            low_half_reg   <= 1'b0;
            poll_count_reg <= 16'd0;
            cnt_reg        <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    ecfsr_pkg::CFG_CPU_MAX:    cpu_max_reg    <= cfg_data;
                    ecfsr_pkg::CFG_GPU_MAX:    gpu_max_reg    <= cfg_data;
                    ecfsr_pkg::CFG_CPU_ADDR:   cpu_addr_reg   <= cfg_data[7:0];
                    ecfsr_pkg::CFG_GPU_ADDR:   gpu_addr_reg   <= cfg_data[7:0];
                    ecfsr_pkg::CFG_POLL_LIMIT: poll_limit_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            active_fan_reg <= active_fan_next;
            if (cmd.start)
                low_half_reg <= 1'b0;
            else if (cmd.capture_high)
                low_half_reg <= 1'b1;

            if (cmd.poll_reset)
                poll_count_reg <= 16'd1;
            else if (cmd.poll_inc)
                poll_count_reg <= poll_count_reg + 16'd1;

            if (cmd.div_init)
                cnt_reg <= CW'(NW);
            else if (cmd.div_step)
                cnt_reg <= cnt_reg - CW'(1);
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture_high)
            speed_high_reg <= in_item.port_data;
        if (cmd.capture_low)
            speed_reg <= {speed_high_reg, in_item.port_data};
        if (cmd.div_init)
        begin
            num_reg <= num_init;
            rem_reg <= 16'd0;
            div_reg <= max_eff;
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[NW-2:0], q_bit};
            rem_reg <= q_bit ? rem_diff : rem_shift[15:0];
        end
        if (cmd.load_out)
            out_reg <= out_next;
    end

    assign out_item = out_reg;

endmodule

[hdl/ec_fan_speed_reader.sv]
`timescale 1ns / 1ps

// Host-side fan speed reader for an embedded controller. A start transaction names the fan;
// the block then issues status polls, the read command, the byte address and data reads as
// result transactions, and expects one input transaction back (the port byte) for each port
// read it requests. Two bytes are fetched, high byte first. The block takes one input at a
// time: an input yields either one result or a port write followed by a poll, and the next
// input waits until these results are taken. The final low-byte answer comes from the
// 26-step restoring divider that forms the rounded percentage in tenths (saturated at
// 65535). A wait that uses up poll_limit polls ends with a failure report.
module ec_fan_speed_reader (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [ecfsr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ecfsr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  ecfsr_pkg::in_item_t               in_item,
    output logic                              out_valid,
    input  logic                              out_stall,
    output ecfsr_pkg::out_item_t              out_item
);

    ecfsr_pkg::ctrl_cmd_t  cmd;
    ecfsr_pkg::dp_status_t status;

    ecfsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ecfsr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .cmd       (cmd),
        .status    (status),
        .out_item  (out_item)
    );

endmodule
